// ===== rtl/jit3_pkg.sv =====
// ----------------------------------------------------------------------------
// jit3_pkg: Jacobian inverse transpose package
// Widths, sequencer states, operand tables and saturation helper.
// ----------------------------------------------------------------------------
package jit3_pkg;

  localparam int DIMS      = 3;
  localparam int FRAC_BITS = 16;
  localparam int NENT      = DIMS * DIMS;
  localparam int ACC_W     = 48;
  localparam int WIDE_W    = 66;
  localparam int RAW_W     = WIDE_W - FRAC_BITS;
  localparam int NUM_W     = 32 + FRAC_BITS;
  localparam int CNT_W     = 6;

  // sequencer steps in the finish phase
  localparam logic [CNT_W-1:0] COF_LAST_ISSUE = CNT_W'(20);
  localparam logic [CNT_W-1:0] DET_REG        = CNT_W'(22);
  localparam logic [CNT_W-1:0] WDET_ISSUE     = CNT_W'(23);
  localparam logic [CNT_W-1:0] WDET_DONE      = CNT_W'(24);
  localparam logic [CNT_W-1:0] DIV_DONE       = CNT_W'(NUM_W + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_NODE   = 6'b000010,
    S_NARROW = 6'b000100,
    S_COF    = 6'b001000,
    S_DIV    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat32_t;

  function automatic sat32_t sat32(input logic signed [WIDE_W-1:0] v);
    sat32_t r;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sh7FFF_FFFF);
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      r.val  = 32'sh7FFF_FFFF;
      r.clip = 1'b1;
    end else if (v < lo) begin
      r.val  = 32'sh8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [1:0] row_of(input logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] k);
    logic [1:0] c;
    case (k)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // Jacobian entries a..i are indexes 0..8; cofactor m is P(2m) - P(2m+1)
  function automatic logic [7:0] cof_ops(input logic [4:0] op);
    logic [7:0] r;
    case (op)
      5'd0:    r = {4'd4, 4'd8};
      5'd1:    r = {4'd5, 4'd7};
      5'd2:    r = {4'd5, 4'd6};
      5'd3:    r = {4'd3, 4'd8};
      5'd4:    r = {4'd3, 4'd7};
      5'd5:    r = {4'd4, 4'd6};
      5'd6:    r = {4'd2, 4'd7};
      5'd7:    r = {4'd1, 4'd8};
      5'd8:    r = {4'd0, 4'd8};
      5'd9:    r = {4'd2, 4'd6};
      5'd10:   r = {4'd1, 4'd6};
      5'd11:   r = {4'd0, 4'd7};
      5'd12:   r = {4'd1, 4'd5};
      5'd13:   r = {4'd2, 4'd4};
      5'd14:   r = {4'd2, 4'd3};
      5'd15:   r = {4'd0, 4'd5};
      5'd16:   r = {4'd0, 4'd4};
      5'd17:   r = {4'd1, 4'd3};
      5'd18:   r = {4'd0, 4'd0};
      5'd19:   r = {4'd3, 4'd3};
      5'd20:   r = {4'd6, 4'd6};
      default: r = {4'd0, 4'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/jacobian_inverse_transpose_3d.sv =====
// ----------------------------------------------------------------------------
// jacobian_inverse_transpose_3d
// Accumulates a 3x3 Jacobian from node items, then on a finish item forms
// the determinant, weighted determinant and inverse transpose (Q16.16).
// ----------------------------------------------------------------------------
//  channel   | transfer when           | ports
//  ----------+-------------------------+-------------------------------------
//  command   | start_i & !busy_o       | kind_i, node_*_i, deriv_*_i, quad_weight_i
//  result    | result_valid_o          | row_index_o, entry_col*_o, determinant_o,
//            |                         | weighted_det_o, singular_o, saturated_o, last_o
//
// A node item passes nine products through the one 32x32 multiplier,
// each accumulated the cycle after. A finish item runs the cofactor and
// determinant multiplies, then divides nine entries in the bit-serial
// divider (skipped when singular), then emits three result rows.
// busy_o is high throughout; reset clears the accumulators at once.
// Results go out on consecutive cycles and are never held.
module jacobian_inverse_transpose_3d
  import jit3_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               kind_i,
  input  logic signed [31:0] node_x_i,
  input  logic signed [31:0] node_y_i,
  input  logic signed [31:0] node_z_i,
  input  logic signed [31:0] deriv_xi_i,
  input  logic signed [31:0] deriv_eta_i,
  input  logic signed [31:0] deriv_zeta_i,
  input  logic signed [31:0] quad_weight_i,
  output logic               result_valid_o,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] entry_col0_o,
  output logic signed [31:0] entry_col1_o,
  output logic signed [31:0] entry_col2_o,
  output logic signed [31:0] determinant_o,
  output logic signed [31:0] weighted_det_o,
  output logic               singular_o,
  output logic               saturated_o,
  output logic               last_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [3:0]       ent_q;
  logic [1:0]       row_q;

  logic signed [ACC_W-1:0] acc_q [NENT];
  logic                    acc_clip_q;
  logic signed [31:0]      coord_q [DIMS];
  logic signed [31:0]      deriv_q [DIMS];
  logic signed [31:0]      weight_q;
  logic signed [31:0]      jn_q [NENT];
  logic signed [31:0]      cof_q [NENT];
  logic signed [31:0]      res_q [NENT];
  logic signed [63:0]      prod_q;
  logic signed [63:0]      hold_q;
  logic signed [RAW_W-1:0] raw_q;
  logic signed [31:0]      det_q;
  logic signed [31:0]      wdet_q;
  logic                    sing_q;
  logic                    gclip_q;
  logic [DIMS-1:0]         rclip_q;

  logic [NUM_W-1:0] dvd_q;
  logic [RAW_W-1:0] dsr_q;
  logic [RAW_W-1:0] rem_q;
  logic             neg_q;

  logic signed [31:0] mul_a, mul_b;
  logic [7:0]         op_sel;
  logic               accept;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    op_sel = cof_ops(cnt_q[4:0]);
    case (state_q)
      S_NODE: begin
        mul_a = coord_q[row_of(cnt_q[3:0])];
        mul_b = deriv_q[col_of(cnt_q[3:0])];
      end
      S_COF: begin
        if (cnt_q < CNT_W'(18)) begin
          mul_a = jn_q[op_sel[7:4]];
          mul_b = jn_q[op_sel[3:0]];
        end else if (cnt_q <= COF_LAST_ISSUE) begin
          mul_a = jn_q[op_sel[7:4]];
          mul_b = cof_q[op_sel[3:0]];
        end else if (cnt_q == WDET_ISSUE) begin
          mul_a = det_q;
          mul_b = weight_q;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // wide helpers
  logic [3:0]               prev_k;
  logic signed [WIDE_W-1:0] prod_sh;
  logic signed [WIDE_W-1:0] acc_sum;
  logic signed [WIDE_W-1:0] acc_hi, acc_lo;
  logic signed [WIDE_W-1:0] cof_diff;
  sat32_t                   cof_sat, det_sat, wdet_sat;
  logic [RAW_W:0]           rem_sh;
  logic                     rem_ge;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         q_max_pos, q_max_neg;
  logic signed [31:0]       q_val;
  logic                     q_clip;
  sat32_t                   jn_sat [NENT];
  logic                     narrow_clip;

  always_comb begin
    narrow_clip = 1'b0;
    for (int k = 0; k < NENT; k++) begin
      jn_sat[k]   = sat32(WIDE_W'(acc_q[k]));
      narrow_clip = narrow_clip | jn_sat[k].clip;
    end
  end

  always_comb begin
    prev_k   = cnt_q[3:0] - 4'd1;
    prod_sh  = WIDE_W'(prod_q >>> FRAC_BITS);
    acc_sum  = WIDE_W'(acc_q[prev_k]) + prod_sh;
    acc_hi   = WIDE_W'(64'sh7FFF_FFFF_FFFF);
    acc_lo   = -acc_hi - WIDE_W'(1);
    cof_diff = (WIDE_W'(hold_q) - WIDE_W'(prod_q)) >>> FRAC_BITS;
    cof_sat  = sat32(cof_diff);
    det_sat  = sat32(WIDE_W'(raw_q));
    wdet_sat = sat32(prod_sh);
    rem_sh   = {rem_q, dvd_q[NUM_W-1]};
    rem_ge   = (rem_sh >= {1'b0, dsr_q});
    num      = NUM_W'(cof_q[ent_q]) <<< FRAC_BITS;
    q_max_pos = NUM_W'(32'h7FFF_FFFF);
    q_max_neg = NUM_W'(33'h8000_0000);
    q_clip   = 1'b0;
    if (neg_q) begin
      if (dvd_q > q_max_neg) begin
        q_val  = 32'sh8000_0000;
        q_clip = 1'b1;
      end else begin
        q_val  = -$signed(dvd_q[31:0]);
      end
    end else begin
      if (dvd_q > q_max_pos) begin
        q_val  = 32'sh7FFF_FFFF;
        q_clip = 1'b1;
      end else begin
        q_val  = $signed(dvd_q[31:0]);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = kind_i ? S_NARROW : S_NODE;
      S_NODE:   if (cnt_q == CNT_W'(NENT)) state_d = S_IDLE;
      S_NARROW: state_d = S_COF;
      S_COF:    if (cnt_q == WDET_DONE) state_d = sing_q ? S_EMIT : S_DIV;
      S_DIV:    if (cnt_q == DIV_DONE && ent_q == 4'(NENT - 1)) state_d = S_EMIT;
      S_EMIT:   if (row_q == 2'(DIMS - 1)) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      ent_q      <= '0;
      row_q      <= '0;
      acc_clip_q <= 1'b0;
      for (int k = 0; k < NENT; k++) acc_q[k] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          ent_q <= '0;
          row_q <= '0;
        end
        S_NODE: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q != '0) begin
            if (acc_sum > acc_hi) begin
              acc_q[prev_k] <= acc_hi[ACC_W-1:0];
              acc_clip_q    <= 1'b1;
            end else if (acc_sum < acc_lo) begin
              acc_q[prev_k] <= acc_lo[ACC_W-1:0];
              acc_clip_q    <= 1'b1;
            end else begin
              acc_q[prev_k] <= acc_sum[ACC_W-1:0];
            end
          end
        end
        S_NARROW: begin
          // narrowed copy taken alongside; clear for the next point
          for (int k = 0; k < NENT; k++) acc_q[k] <= '0;
          acc_clip_q <= 1'b0;
          cnt_q      <= '0;
        end
        S_COF: begin
          cnt_q <= (cnt_q == WDET_DONE) ? '0 : cnt_q + CNT_W'(1);
        end
        S_DIV: begin
          if (cnt_q == DIV_DONE) begin
            cnt_q <= '0;
            ent_q <= ent_q + 4'd1;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_EMIT: row_q <= row_q + 2'd1;
        default: cnt_q <= '0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      coord_q[0] <= node_x_i;
      coord_q[1] <= node_y_i;
      coord_q[2] <= node_z_i;
      deriv_q[0] <= deriv_xi_i;
      deriv_q[1] <= deriv_eta_i;
      deriv_q[2] <= deriv_zeta_i;
      weight_q   <= quad_weight_i;
    end
    if (state_q == S_NARROW) begin
      gclip_q <= acc_clip_q | narrow_clip;
      rclip_q <= '0;
      for (int k = 0; k < NENT; k++) jn_q[k] <= jn_sat[k].val;
    end
    if (state_q == S_COF && cnt_q != '0) begin
      if (cnt_q <= CNT_W'(18)) begin
        if (cnt_q[0]) begin
          hold_q <= prod_q;
        end else begin
          cof_q[cnt_q[4:1] - 4'd1] <= cof_sat.val;
          if (cof_sat.clip) gclip_q <= 1'b1;
        end
      end else if (cnt_q <= COF_LAST_ISSUE + CNT_W'(1)) begin
        raw_q <= ((cnt_q == CNT_W'(19)) ? RAW_W'(0) : raw_q) + prod_sh[RAW_W-1:0];
      end else if (cnt_q == DET_REG) begin
        det_q  <= det_sat.val;
        sing_q <= (raw_q == '0);
        if (det_sat.clip) gclip_q <= 1'b1;
      end else if (cnt_q == WDET_DONE) begin
        wdet_q <= wdet_sat.val;
        if (wdet_sat.clip) gclip_q <= 1'b1;
      end
    end
    if (state_q == S_DIV) begin
      if (cnt_q == '0) begin
        dvd_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dsr_q <= raw_q[RAW_W-1] ? RAW_W'(-raw_q) : RAW_W'(raw_q);
        rem_q <= '0;
        neg_q <= num[NUM_W-1] ^ raw_q[RAW_W-1];
      end else if (cnt_q == DIV_DONE) begin
        res_q[ent_q] <= q_val;
        if (q_clip) rclip_q[row_of(ent_q)] <= 1'b1;
      end else begin
        rem_q <= rem_ge ? RAW_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[RAW_W-1:0];
        dvd_q <= {dvd_q[NUM_W-2:0], rem_ge};
      end
    end
  end

  // result ports
  always_comb begin
    result_valid_o = (state_q == S_EMIT);
    row_index_o    = row_q;
    entry_col0_o   = '0;
    entry_col1_o   = '0;
    entry_col2_o   = '0;
    if (!sing_q) begin
      case (row_q)
        2'd0: begin
          entry_col0_o = res_q[0];
          entry_col1_o = res_q[1];
          entry_col2_o = res_q[2];
        end
        2'd1: begin
          entry_col0_o = res_q[3];
          entry_col1_o = res_q[4];
          entry_col2_o = res_q[5];
        end
        default: begin
          entry_col0_o = res_q[6];
          entry_col1_o = res_q[7];
          entry_col2_o = res_q[8];
        end
      endcase
    end
    determinant_o  = det_q;
    weighted_det_o = wdet_q;
    singular_o     = sing_q;
    saturated_o    = gclip_q | rclip_q[row_q];
    last_o         = (row_q == 2'(DIMS - 1));
  end

endmodule
